// ----- rtl/chacha_pkg.sv -----
// ----------------------------------------------------------------------------
// chacha_pkg
// Shared constants, types and the block input word builder of the ChaCha20
// stream core.
// ----------------------------------------------------------------------------
package chacha_pkg;

   localparam int DOUBLE_ROUNDS = 10;
   localparam int DROUND_W      = $clog2(DOUBLE_ROUNDS);

   localparam int CSR_ADDR_W    = 6;
   localparam int CSR_DATA_W    = 64;

   localparam logic [31:0] SIGMA_0 = 32'h6170_7865;
   localparam logic [31:0] SIGMA_1 = 32'h3320_646e;
   localparam logic [31:0] SIGMA_2 = 32'h7962_2d32;
   localparam logic [31:0] SIGMA_3 = 32'h6b20_6574;

   localparam logic [5:0] POS_LAST = 6'd63;

   // register indexes (paddr[5:3])
   localparam logic [2:0] REG_KEY_0       = 3'd0;
   localparam logic [2:0] REG_KEY_1       = 3'd1;
   localparam logic [2:0] REG_KEY_2       = 3'd2;
   localparam logic [2:0] REG_KEY_3       = 3'd3;
   localparam logic [2:0] REG_NONCE       = 3'd4;
   localparam logic [2:0] REG_START_BLOCK = 3'd5;
   localparam logic [2:0] REG_START_BYTE  = 3'd6;

   typedef struct packed {
      logic [3:0][63:0] key;
      logic [63:0]      nonce;
      logic             restart;
      logic [63:0]      restart_block;
      logic [5:0]       restart_byte;
   } cfg_type;

   function automatic logic [31:0] init_word(input cfg_type cfg,
                                             input logic [63:0] counter,
                                             input logic [3:0] idx);
      logic [31:0] w;
      unique case (idx)
         4'd0:  w = SIGMA_0;
         4'd1:  w = SIGMA_1;
         4'd2:  w = SIGMA_2;
         4'd3:  w = SIGMA_3;
         4'd4:  w = cfg.key[0][31:0];
         4'd5:  w = cfg.key[0][63:32];
         4'd6:  w = cfg.key[1][31:0];
         4'd7:  w = cfg.key[1][63:32];
         4'd8:  w = cfg.key[2][31:0];
         4'd9:  w = cfg.key[2][63:32];
         4'd10: w = cfg.key[3][31:0];
         4'd11: w = cfg.key[3][63:32];
         4'd12: w = counter[31:0];
         4'd13: w = counter[63:32];
         4'd14: w = cfg.nonce[31:0];
         4'd15: w = cfg.nonce[63:32];
      endcase
      return w;
   endfunction

endpackage

// ----- rtl/chacha_if.sv -----
// ----------------------------------------------------------------------------
// chacha_req_if / chacha_rsp_if
// Valid/ready channels carrying input bytes and result bytes.
// ----------------------------------------------------------------------------
interface chacha_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       keystream_only;

   modport source (output valid, data_byte, keystream_only, input ready);
   modport sink   (input valid, data_byte, keystream_only, output ready);
endinterface

interface chacha_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;

   modport source (output valid, out_byte, input ready);
   modport sink   (input valid, out_byte, output ready);
endinterface

// ----- rtl/chacha_csr.sv -----
// ----------------------------------------------------------------------------
// chacha_csr
// APB-style register file: key, nonce and stream start position.
// ----------------------------------------------------------------------------
module chacha_csr
   import chacha_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   logic [3:0][63:0] key_ff, key_in;
   logic [63:0]      nonce_ff, nonce_in;
   logic [63:0]      start_block_ff, start_block_in;
   logic [5:0]       start_byte_ff, start_byte_in;
   logic [2:0]       idx;
   logic             wr;
   logic             wr_hit;

   assign csr_pready = 1'b1;
   assign idx        = csr_paddr[5:3];
   assign wr         = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      key_in         = key_ff;
      nonce_in       = nonce_ff;
      start_block_in = start_block_ff;
      start_byte_in  = start_byte_ff;
      wr_hit         = 1'b0;
      if (wr) begin
         wr_hit = 1'b1;
         unique case (idx)
            REG_KEY_0:       key_in[0]      = csr_pwdata;
            REG_KEY_1:       key_in[1]      = csr_pwdata;
            REG_KEY_2:       key_in[2]      = csr_pwdata;
            REG_KEY_3:       key_in[3]      = csr_pwdata;
            REG_NONCE:       nonce_in       = csr_pwdata;
            REG_START_BLOCK: start_block_in = csr_pwdata;
            REG_START_BYTE:  start_byte_in  = csr_pwdata[5:0];
            default:         wr_hit         = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff         <= '0;
         nonce_ff       <= '0;
         start_block_ff <= '0;
         start_byte_ff  <= '0;
      end else begin
         key_ff         <= key_in;
         nonce_ff       <= nonce_in;
         start_block_ff <= start_block_in;
         start_byte_ff  <= start_byte_in;
      end
   end

   always_comb begin
      unique case (idx)
         REG_KEY_0:       csr_prdata = key_ff[0];
         REG_KEY_1:       csr_prdata = key_ff[1];
         REG_KEY_2:       csr_prdata = key_ff[2];
         REG_KEY_3:       csr_prdata = key_ff[3];
         REG_NONCE:       csr_prdata = nonce_ff;
         REG_START_BLOCK: csr_prdata = start_block_ff;
         REG_START_BYTE:  csr_prdata = {{(CSR_DATA_W-6){1'b0}}, start_byte_ff};
         default:         csr_prdata = '0;
      endcase
   end

   // restart position takes the value being written in the same transfer
   assign cfg.key           = key_ff;
   assign cfg.nonce         = nonce_ff;
   assign cfg.restart       = wr_hit;
   assign cfg.restart_block = start_block_in;
   assign cfg.restart_byte  = start_byte_in;

endmodule

// ----- rtl/chacha_qr_unit.sv -----
// ----------------------------------------------------------------------------
// chacha_qr_unit
// One quarter-round line: add, xor and fixed rotate chosen by step.
// ----------------------------------------------------------------------------
module chacha_qr_unit
   import chacha_pkg::*;
(
   input  logic [31:0] opa,
   input  logic [31:0] opb,
   input  logic [31:0] opz,
   input  logic [1:0]  step,
   output logic [31:0] sum,
   output logic [31:0] mix
);

   logic [31:0] x;

   assign sum = opa + opb;
   assign x   = opz ^ sum;

   always_comb begin
      unique case (step)
         2'd0: mix = {x[15:0], x[31:16]};
         2'd1: mix = {x[19:0], x[31:20]};
         2'd2: mix = {x[23:0], x[31:24]};
         2'd3: mix = {x[24:0], x[31:25]};
      endcase
   end

endmodule

// ----- rtl/chacha_engine.sv -----
// ----------------------------------------------------------------------------
// chacha_engine
// Block sequencer: word array, round control, feed-forward and byte output.
// ----------------------------------------------------------------------------
module chacha_engine
   import chacha_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   chacha_req_if.sink   req_ch,
   chacha_rsp_if.source rsp_ch
);

   typedef logic [15:0][31:0] words_type;

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b000_0001,
      ST_LOAD     = 7'b000_0010,
      ST_ROUND    = 7'b000_0100,
      ST_DIAG_IN  = 7'b000_1000,
      ST_DIAG_OUT = 7'b001_0000,
      ST_FINAL    = 7'b010_0000,
      ST_EMIT     = 7'b100_0000
   } state_type;

   state_type             state_ff, state_in;
   logic [3:0]            phase_ff, phase_in;
   logic                  diag_ff, diag_in;
   logic [DROUND_W-1:0]   dround_ff, dround_in;
   logic [63:0]           counter_ff, counter_in;
   logic [5:0]            pos_ff, pos_in;
   logic                  blk_ready_ff, blk_ready_in;
   words_type             word_ff, word_in;
   logic [7:0]            data_ff, data_in;
   logic                  ksonly_ff, ksonly_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_byte_ff, rsp_byte_in;

   logic [31:0] opa, opb, opz, sum, mix;
   logic [31:0] ks_word;
   logic [7:0]  ks_byte;
   logic        accept;

   // rotate each row of four words left by its own amount
   function automatic words_type rotate_rows(input words_type w,
                                             input logic [3:0][1:0] sh);
      words_type o;
      logic [1:0] cc;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            cc = 2'(c) + sh[r];
            o[4*r+c] = w[4*r+int'(cc)];
         end
      end
      return o;
   endfunction

   chacha_qr_unit u_qr (
      .opa  (opa),
      .opb  (opb),
      .opz  (opz),
      .step (phase_ff[1:0]),
      .sum  (sum),
      .mix  (mix)
   );

   assign req_ch.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign accept       = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.out_byte = rsp_byte_ff;

   // operand selection: the active column always sits at word position 0
   always_comb begin
      if (state_ff == ST_FINAL) begin
         opa = word_ff[0];
         opb = init_word(cfg, counter_ff, phase_ff);
         opz = '0;
      end else if (!phase_ff[0]) begin
         opa = word_ff[0];
         opb = word_ff[4];
         opz = word_ff[12];
      end else begin
         opa = word_ff[8];
         opb = word_ff[12];
         opz = word_ff[4];
      end
   end

   assign ks_word = word_ff[pos_ff[5:2]];

   always_comb begin
      unique case (pos_ff[1:0])
         2'd0: ks_byte = ks_word[7:0];
         2'd1: ks_byte = ks_word[15:8];
         2'd2: ks_byte = ks_word[23:16];
         2'd3: ks_byte = ks_word[31:24];
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      diag_in      = diag_ff;
      dround_in    = dround_ff;
      counter_in   = counter_ff;
      pos_in       = pos_ff;
      blk_ready_in = blk_ready_ff;
      word_in      = word_ff;
      data_in      = data_ff;
      ksonly_in    = ksonly_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               data_in   = req_ch.data_byte;
               ksonly_in = req_ch.keystream_only;
               state_in  = blk_ready_ff ? ST_EMIT : ST_LOAD;
            end
         end
         ST_LOAD: begin
            for (int i = 0; i < 16; i++) begin
               word_in[i] = init_word(cfg, counter_ff, 4'(i));
            end
            phase_in  = '0;
            diag_in   = 1'b0;
            dround_in = '0;
            state_in  = ST_ROUND;
         end
         ST_ROUND: begin
            if (!phase_ff[0]) begin
               word_in[0]  = sum;
               word_in[12] = mix;
            end else begin
               word_in[8]  = sum;
               word_in[4]  = mix;
            end
            phase_in = phase_ff + 4'd1;
            // quarter round done: bring the next column to position 0
            if (phase_ff[1:0] == 2'd3) begin
               word_in = rotate_rows(word_in, {2'd1, 2'd1, 2'd1, 2'd1});
               if (phase_ff[3:2] == 2'd3) begin
                  state_in = diag_ff ? ST_DIAG_OUT : ST_DIAG_IN;
               end
            end
         end
         ST_DIAG_IN: begin
            word_in  = rotate_rows(word_ff, {2'd3, 2'd2, 2'd1, 2'd0});
            diag_in  = 1'b1;
            state_in = ST_ROUND;
         end
         ST_DIAG_OUT: begin
            word_in = rotate_rows(word_ff, {2'd1, 2'd2, 2'd3, 2'd0});
            diag_in = 1'b0;
            if (dround_ff == DROUND_W'(DOUBLE_ROUNDS - 1)) begin
               state_in = ST_FINAL;
            end else begin
               dround_in = dround_ff + DROUND_W'(1);
               state_in  = ST_ROUND;
            end
         end
         ST_FINAL: begin
            // feed-forward, one word a cycle through the shared adder
            for (int i = 0; i < 15; i++) begin
               word_in[i] = word_ff[i+1];
            end
            word_in[15] = sum;
            phase_in    = phase_ff + 4'd1;
            if (phase_ff == 4'd15) begin
               counter_in   = counter_ff + 64'd1;
               blk_ready_in = 1'b1;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_byte_in  = ksonly_ff ? ks_byte : (ks_byte ^ data_ff);
            rsp_valid_in = 1'b1;
            pos_in       = pos_ff + 6'd1;
            if (pos_ff == POS_LAST) begin
               blk_ready_in = 1'b0;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cfg.restart) begin
         counter_in   = cfg.restart_block;
         pos_in       = cfg.restart_byte;
         blk_ready_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= '0;
         diag_ff      <= 1'b0;
         dround_ff    <= '0;
         counter_ff   <= '0;
         pos_ff       <= '0;
         blk_ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         diag_ff      <= diag_in;
         dround_ff    <= dround_in;
         counter_ff   <= counter_in;
         pos_ff       <= pos_in;
         blk_ready_ff <= blk_ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      data_ff     <= data_in;
      ksonly_ff   <= ksonly_in;
      rsp_byte_ff <= rsp_byte_in;
   end

endmodule

// ----- rtl/chacha20_stream_xor_core.sv -----
// ----------------------------------------------------------------------------
// chacha20_stream_xor_core
// ChaCha20 stream cipher (64-bit nonce, 64-bit block counter), byte wide.
// ----------------------------------------------------------------------------
// usage:
//   req_ch  : one transfer per byte (data_byte, keystream_only)
//   rsp_ch  : one transfer per byte (out_byte = data ^ keystream, or keystream)
//   csr_*   : 64-bit registers at 8*i: key words 0..3, nonce, start block,
//             start byte; any write to these restarts the stream at the start position
// sequencing:
//   a byte from a cached block goes through ST_EMIT into the result register,
//   and the core takes the next byte only once it is back in ST_IDLE
//   a byte that needs a new block first passes ST_LOAD, DOUBLE_ROUNDS double
//   rounds and ST_FINAL; the single quarter-round line unit
//   does one add/xor/rotate a cycle, 4 per quarter round, plus a row
//   shuffle into and out of each diagonal round and a feed-forward over 16 words
// reset: counter, position and cached block flag clear, registers read zero
// stall: a held result keeps req_ch.ready low until it is taken
// ----------------------------------------------------------------------------
module chacha20_stream_xor_core
   import chacha_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   chacha_req_if.sink            req_ch,
   chacha_rsp_if.source          rsp_ch
);

   cfg_type cfg;

   chacha_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   chacha_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

endmodule

// ----- tb/tb_chacha20_stream_xor_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_chacha20_stream_xor_core
// Streams bytes through the cipher core under random back-pressure and
// compares every result byte against an in-bench ChaCha20 keystream model.
// Mapped register writes restart the stream and are read back over the same port.
// ----------------------------------------------------------------------------
module tb_chacha20_stream_xor_core;
   import chacha_pkg::*;

   localparam logic [2:0] REG_UNUSED = 3'd7;
   localparam int CYCLE_LIMIT = 400000;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   chacha_req_if req_if ();
   chacha_rsp_if rsp_if ();

   chacha20_stream_xor_core uut (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if)
   );

   // cipher state as the bench sees it
   logic [63:0] cfg_key [4];
   logic [63:0] cfg_nonce;
   logic [63:0] cfg_block;
   logic [5:0]  cfg_byte;
   logic [63:0] ctr;
   logic [5:0]  pos;
   logic        have_block;
   logic [31:0] ks_words [16];
   logic [31:0] mix_w [16];

   logic [7:0]  exp_out_q [$];
   logic [7:0]  want_byte;
   bit          pace_on;
   int          mismatches;
   int          bytes_checked;
   int          blocks_made;
   int          csr_writes;
   int          cycle_count;

   always #5 clock = ~clock;

   function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
      return (v << n) | (v >> (32 - n));
   endfunction

   function automatic void mix_quad(input int a, input int b, input int c, input int d);
      mix_w[a] = mix_w[a] + mix_w[b]; mix_w[d] = rotl(mix_w[d] ^ mix_w[a], 16);
      mix_w[c] = mix_w[c] + mix_w[d]; mix_w[b] = rotl(mix_w[b] ^ mix_w[c], 12);
      mix_w[a] = mix_w[a] + mix_w[b]; mix_w[d] = rotl(mix_w[d] ^ mix_w[a], 8);
      mix_w[c] = mix_w[c] + mix_w[d]; mix_w[b] = rotl(mix_w[b] ^ mix_w[c], 7);
   endfunction

   function automatic void make_keystream_block();
      logic [31:0] init [16];
      int k;
      init[0] = SIGMA_0;
      init[1] = SIGMA_1;
      init[2] = SIGMA_2;
      init[3] = SIGMA_3;
      for (k = 0; k < 4; k++) begin
         init[4 + 2 * k] = cfg_key[k][31:0];
         init[5 + 2 * k] = cfg_key[k][63:32];
      end
      init[12] = ctr[31:0];
      init[13] = ctr[63:32];
      init[14] = cfg_nonce[31:0];
      init[15] = cfg_nonce[63:32];
      for (k = 0; k < 16; k++) mix_w[k] = init[k];
      for (k = 0; k < DOUBLE_ROUNDS; k++) begin
         mix_quad(0, 4, 8, 12);
         mix_quad(1, 5, 9, 13);
         mix_quad(2, 6, 10, 14);
         mix_quad(3, 7, 11, 15);
         mix_quad(0, 5, 10, 15);
         mix_quad(1, 6, 11, 12);
         mix_quad(2, 7, 8, 13);
         mix_quad(3, 4, 9, 14);
      end
      for (k = 0; k < 16; k++) ks_words[k] = mix_w[k] + init[k];
      ctr = ctr + 64'd1;
      have_block = 1'b1;
      blocks_made++;
   endfunction

   function automatic logic [7:0] predict_out_byte(input logic [7:0] d, input logic ks_only);
      logic [31:0] w;
      logic [7:0]  ks;
      if (!have_block) make_keystream_block();
      w = ks_words[pos[5:2]] >> {pos[1:0], 3'b000};
      ks = w[7:0];
      pos = pos + 6'd1;
      // block used up once the position wraps
      if (pos == 6'd0) have_block = 1'b0;
      return ks_only ? ks : (ks ^ d);
   endfunction

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_if.ready <= (pace_on && $urandom_range(0, 99) < 32) ? 1'b0 : 1'b1;
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (exp_out_q.size() == 0) begin
            $display("%0t: out_byte transfer with none expected, actual %02h",
                     $time, rsp_if.out_byte);
            mismatches++;
         end else begin
            want_byte = exp_out_q.pop_front();
            if (rsp_if.out_byte !== want_byte) begin
               $display("%0t: out_byte expected %02h actual %02h",
                        $time, want_byte, rsp_if.out_byte);
               mismatches++;
            end
            bytes_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timed out with %0d bytes outstanding", $time, exp_out_q.size());
         $display("tb_chacha20_stream_xor_core failed");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] d, input logic ks_only);
      while (pace_on && $urandom_range(0, 99) < 32) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data_byte <= d;
      req_if.keystream_only <= ks_only;
      @(posedge clock);
      while (!(req_if.valid && req_if.ready)) @(posedge clock);
      exp_out_q.push_back(predict_out_byte(d, ks_only));
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (exp_out_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // write, then read a mapped register back while psel is still held
   task automatic csr_write(input logic [2:0] idx, input logic [63:0] value);
      logic [63:0] want;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 3'b000};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_writes++;
      case (idx)
         REG_KEY_0, REG_KEY_1, REG_KEY_2, REG_KEY_3: cfg_key[idx] = value;
         REG_NONCE:       cfg_nonce = value;
         REG_START_BLOCK: cfg_block = value;
         REG_START_BYTE:  cfg_byte = value[5:0];
         default: ;
      endcase
      if (idx != REG_UNUSED) begin
         ctr = cfg_block;
         pos = cfg_byte;
         have_block = 1'b0;
      end
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (idx == REG_UNUSED) begin
         csr_psel <= 1'b0;
      end else begin
         @(negedge clock);
         csr_penable <= 1'b1;
         @(posedge clock);
         case (idx)
            REG_NONCE:       want = cfg_nonce;
            REG_START_BLOCK: want = cfg_block;
            REG_START_BYTE:  want = {58'd0, cfg_byte};
            default:         want = cfg_key[idx];
         endcase
         if (csr_prdata !== want) begin
            $display("%0t: register %0d readback expected %016h actual %016h",
                     $time, idx, want, csr_prdata);
            mismatches++;
         end
         @(negedge clock);
         csr_psel <= 1'b0;
         csr_penable <= 1'b0;
      end
      @(negedge clock);
   endtask

   // all-zero key straight out of reset, both modes, data extremes
   task automatic test_reset_stream();
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'h5a, 1'b1);
      send_byte(8'hff, 1'b1);
   endtask

   // last two bytes of the top block, then the counter wraps to block zero
   task automatic test_counter_wrap();
      int k;
      wait_drained();
      for (k = 0; k < 4; k++) csr_write(3'(k), '1);
      csr_write(REG_NONCE, '1);
      csr_write(REG_START_BLOCK, '1);
      csr_write(REG_START_BYTE, 64'd62);
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b1);
      send_byte(8'ha5, 1'b0);
      send_byte(8'h3c, 1'b1);
   endtask

   // writes above the register map must leave the stream where it is
   task automatic test_unused_register();
      wait_drained();
      csr_write(REG_UNUSED, {$urandom, $urandom});
      send_byte(8'h81, 1'b0);
      send_byte(8'h7e, 1'b0);
      send_byte(8'h00, 1'b1);
   endtask

   // seek to the last byte of a block, then restart via a key write
   task automatic test_seek_restart();
      wait_drained();
      csr_write(REG_START_BLOCK, {$urandom, $urandom});
      csr_write(REG_START_BYTE, 64'd63);
      send_byte(8'hc3, 1'b0);
      send_byte(8'h18, 1'b1);
      wait_drained();
      csr_write(REG_KEY_2, {$urandom, $urandom});
      send_byte(8'hf0, 1'b0);
      send_byte(8'h0f, 1'b0);
   endtask

   task automatic test_random_stream();
      int ph;
      int r;
      int n;
      int k;
      logic [2:0]  ri;
      logic [63:0] v;
      for (ph = 0; ph < 8; ph++) begin
         wait_drained();
         pace_on = (ph != 3);
         for (r = 0; r <= int'(REG_START_BYTE); r++) begin
            if (ph == 0 || $urandom_range(0, 3) != 0) begin
               ri = 3'(r);
               case ($urandom_range(0, 5))
                  0:       v = '0;
                  1:       v = '1;
                  default: v = {$urandom, $urandom};
               endcase
               if (ri == REG_START_BYTE) begin
                  case ($urandom_range(0, 3))
                     0:       v = 64'd0;
                     1:       v = 64'd63;
                     default: v = 64'($urandom_range(0, 63));
                  endcase
               end else if (ri == REG_START_BLOCK && $urandom_range(0, 2) == 0) begin
                  v = 64'hffff_ffff_ffff_ffff - 64'($urandom_range(0, 2));
               end
               csr_write(ri, v);
            end
         end
         n = 130 + $urandom_range(0, 60);
         for (k = 0; k < n; k++) begin
            // halfway through even phases the sender holds off until the pipe is empty
            if (k == n / 2 && ph % 2 == 0) wait_drained();
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
         end
      end
      pace_on = 1'b1;
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      req_if.valid = 1'b0;
      req_if.data_byte = 8'h00;
      req_if.keystream_only = 1'b0;
      rsp_if.ready = 1'b0;
      for (int k = 0; k < 4; k++) cfg_key[k] = '0;
      cfg_nonce = '0;
      cfg_block = '0;
      cfg_byte = '0;
      ctr = '0;
      pos = '0;
      have_block = 1'b0;
      pace_on = 1'b1;
      mismatches = 0;
      bytes_checked = 0;
      blocks_made = 0;
      csr_writes = 0;
      cycle_count = 0;

      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_stream();
      test_counter_wrap();
      test_unused_register();
      test_seek_restart();
      test_random_stream();

      wait_drained();
      repeat (20) @(negedge clock);

      $display("%0d bytes checked over %0d keystream blocks, %0d register writes",
               bytes_checked, blocks_made, csr_writes);
      $display("xor and keystream-only modes, seeks, counter wrap, stalls on both sides");
      if (mismatches == 0) begin
         $display("tb_chacha20_stream_xor_core passed");
      end else begin
         $display("tb_chacha20_stream_xor_core failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/chacha_pkg.sv
rtl/chacha_if.sv
rtl/chacha_csr.sv
rtl/chacha_qr_unit.sv
rtl/chacha_engine.sv
rtl/chacha20_stream_xor_core.sv
tb/tb_chacha20_stream_xor_core.sv
